[rtl/core/drc_pkg.sv]
// Shared types, constants and divider step function for the difficulty retarget core.
package drc_pkg;

	localparam int unsigned VW = 256;
	localparam int unsigned DIV_BITS = 4;
	localparam int unsigned DIV_STAGES = VW / DIV_BITS;

	localparam logic [1:0] CFG_NO_RETARGET = 2'd0;
	localparam logic [1:0] CFG_TIMESPAN_WIDE = 2'd1;
	localparam logic [1:0] CFG_TIMESPAN_NARROW = 2'd2;
	localparam logic [1:0] CFG_LIMIT_COMPACT = 2'd3;

	localparam logic RST_NO_RETARGET = 1'b0;
	localparam logic [30:0] RST_TIMESPAN_WIDE = 31'd302400;
	localparam logic [30:0] RST_TIMESPAN_NARROW = 31'd302400;
	localparam logic [31:0] RST_LIMIT_COMPACT = 32'd504365055;

	localparam logic [32:0] H_WIDE_END = 33'd76000;
	localparam logic [32:0] H_NARROW_END = 33'd329529;
	localparam logic [32:0] H_LIMIT_END = 33'd330000;
	localparam logic [10:0] PRESHIFT_BITS = 11'd235;

	typedef struct packed {
		logic pass;
		logic force_lim;
		logic shifted;
		logic [31:0] bits;
	} side_t;

	typedef struct packed {
		logic [30:0] rem;
		logic [VW-1:0] x;
	} div_res_t;

	// Four restoring division steps; quotient bits shift into the low end of x.
	function automatic div_res_t div_bits(logic [30:0] rem_in, logic [VW-1:0] x_in,
		logic [30:0] t);
		div_res_t r;
		logic [31:0] rem2;
		r.rem = rem_in;
		r.x = x_in;
		for (int k = 0; k < DIV_BITS; k++) begin
			rem2 = {r.rem, r.x[VW-1]};
			r.x = {r.x[VW-2:0], 1'b0};
			if (rem2 >= {1'b0, t}) begin
				rem2 = rem2 - {1'b0, t};
				r.x[0] = 1'b1;
			end
			r.rem = rem2[30:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/difficulty_retarget_compact_core.sv]
// Top level of the compact-target difficulty retarget core.
//
// Channel   Direction  Content
// s_*       in         block_height, last_bits, last_time, first_time
// m_*       out        next_bits
// cfg_*     in         register writes, no read-back
//
// One item enters per cycle unless m_tready stalls the pipeline; each item passes
// through 71 register stages: four front stages, 64 divider stages of four quotient
// bits, and three stages for the cap and the compact encoding.
// Reset clears the valid bits and loads the register defaults.
// A stall at m_tready freezes the whole pipeline; s_tready drops with it.
module difficulty_retarget_compact_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// block_height[31:0], last_bits[63:32], last_time[127:64], first_time[191:128]
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// next_bits[31:0]
	output logic [31:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);

	typedef enum logic [1:0] {MODE_WIDE, MODE_NARROW, MODE_LIMIT} mode_t;

	logic        no_retarget_q;
	logic [30:0] timespan_wide_q;
	logic [30:0] timespan_narrow_q;
	logic [31:0] limit_compact_q;
	logic [drc_pkg::VW-1:0] lim_dec_q;

	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_retarget_q <= drc_pkg::RST_NO_RETARGET;
			timespan_wide_q <= drc_pkg::RST_TIMESPAN_WIDE;
			timespan_narrow_q <= drc_pkg::RST_TIMESPAN_NARROW;
			limit_compact_q <= drc_pkg::RST_LIMIT_COMPACT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				drc_pkg::CFG_NO_RETARGET:     no_retarget_q <= cfg_wdata[0];
				drc_pkg::CFG_TIMESPAN_WIDE:   timespan_wide_q <= cfg_wdata[30:0];
				drc_pkg::CFG_TIMESPAN_NARROW: timespan_narrow_q <= cfg_wdata[30:0];
				drc_pkg::CFG_LIMIT_COMPACT:   limit_compact_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Decoded limit, refreshed every cycle from the register.
	logic [drc_pkg::VW-1:0] lim_dec;
	always_comb begin
		logic [7:0]  le;
		logic [22:0] lm;
		logic [10:0] lsh;
		le = limit_compact_q[31:24];
		lm = limit_compact_q[22:0];
		lsh = {le, 3'b000} - 11'd24;
		lim_dec = '0;
		if (le <= 8'd3) begin
			lim_dec = drc_pkg::VW'(lm >> {2'd3 - le[1:0], 3'b000});
		end else if (lsh < 11'd256) begin
			lim_dec = drc_pkg::VW'(lm) << lsh[7:0];
		end
	end

	always_ff @(posedge clk) begin
		lim_dec_q <= lim_dec;
	end

	// Stage 1: mode, timespan bounds, exact timestamp difference.
	logic        vld_s1;
	logic [64:0] diff_s1;
	logic [32:0] lo_s1, hi_s1;
	logic [30:0] t_s1;
	drc_pkg::side_t side_s1;

	mode_t       mode;
	logic [32:0] nh;
	logic [30:0] t_sel;
	logic [32:0] lo, hi;
	logic [64:0] diff;
	drc_pkg::side_t side0;

	always_comb begin
		nh = {1'b0, s_tdata[31:0]} + 33'd1;
		if (nh < drc_pkg::H_WIDE_END) begin
			mode = MODE_WIDE;
		end else if (nh < drc_pkg::H_NARROW_END) begin
			mode = MODE_NARROW;
		end else if (nh < drc_pkg::H_LIMIT_END) begin
			mode = MODE_LIMIT;
		end else begin
			mode = MODE_NARROW;
		end
		t_sel = (mode == MODE_WIDE) ? timespan_wide_q : timespan_narrow_q;
		if (mode == MODE_WIDE) begin
			lo = 33'(t_sel >> 2);
			hi = {t_sel, 2'b00};
		end else begin
			lo = 33'(t_sel) - 33'(t_sel >> 2);
			hi = 33'(t_sel) + 33'(t_sel >> 1);
		end
		diff = {s_tdata[127], s_tdata[127:64]} - {s_tdata[191], s_tdata[191:128]};
		side0.pass = (mode != MODE_LIMIT) && no_retarget_q;
		side0.force_lim = (mode == MODE_LIMIT) || (t_sel == '0);
		side0.shifted = 1'b0;
		side0.bits = s_tdata[63:32];
	end

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= diff;
			lo_s1 <= lo;
			hi_s1 <= hi;
			t_s1 <= t_sel;
			side_s1 <= side0;
		end
	end

	// Stage 2: clamp the span, split the target into mantissa and shift.
	logic        vld_s2;
	logic [32:0] span_s2;
	logic [22:0] base_s2;
	logic [7:0]  shs_s2;
	logic [30:0] t_s2;
	drc_pkg::side_t side_s2;

	logic [32:0] span;
	logic [22:0] base;
	logic [7:0]  shs;
	logic [4:0]  bl;
	logic [10:0] sh11;
	logic        shifted;
	drc_pkg::side_t side1;

	always_comb begin
		logic [7:0]  e;
		logic [22:0] m;
		logic [22:0] mk;
		e = side_s1.bits[31:24];
		m = side_s1.bits[22:0];
		if (diff_s1[64] || diff_s1 < 65'(lo_s1)) begin
			span = lo_s1;
		end else if (diff_s1 > 65'(hi_s1)) begin
			span = hi_s1;
		end else begin
			span = diff_s1[32:0];
		end
		sh11 = {e, 3'b000} - 11'd24;
		// Mantissa bits that would land at bit 256 or above are lost in the decode.
		mk = m;
		if (sh11 == 11'd240) begin
			mk = {7'b0, m[15:0]};
		end else if (sh11 == 11'd248) begin
			mk = {15'b0, m[7:0]};
		end
		bl = '0;
		for (int i = 0; i < 23; i++) begin
			if (mk[i]) bl = 5'(i + 1);
		end
		shifted = 1'b0;
		base = '0;
		shs = '0;
		if (e <= 8'd3) begin
			base = m >> {2'd3 - e[1:0], 3'b000};
		end else if (sh11 < 11'd256) begin
			base = mk;
			shifted = (bl != '0) && (sh11 + 11'(bl) > drc_pkg::PRESHIFT_BITS);
			shs = sh11[7:0] - 8'(shifted);
		end
		side1 = side_s1;
		side1.shifted = shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_s2 <= span;
			base_s2 <= base;
			shs_s2 <= shs;
			t_s2 <= t_s1;
			side_s2 <= side1;
		end
	end

	// Stage 3: mantissa times span.
	logic        vld_s3;
	logic [55:0] q_s3;
	logic [7:0]  shs_s3;
	logic [30:0] t_s3;
	drc_pkg::side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3 <= 56'(base_s2) * 56'(span_s2);
			shs_s3 <= shs_s2;
			t_s3 <= t_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: place the product in the 256-bit word, high bits dropped.
	logic        vld_s4;
	logic [drc_pkg::VW-1:0] p_s4;
	logic [30:0] t_s4;
	drc_pkg::side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s4 <= drc_pkg::VW'(q_s3) << shs_s3;
			t_s4 <= t_s3;
			side_s4 <= side_s3;
		end
	end

	logic                   vld_dv;
	logic [drc_pkg::VW-1:0] quo_dv;
	drc_pkg::side_t         side_dv;

	drc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s4),
		.in_x      (p_s4),
		.in_t      (t_s4),
		.in_side   (side_s4),
		.out_valid (vld_dv),
		.out_x     (quo_dv),
		.out_side  (side_dv)
	);

	// Stage C1: undo the pre-shift and cap at the limit.
	logic        vld_c1;
	logic [drc_pkg::VW-1:0] v_c1;
	drc_pkg::side_t side_c1;
	logic [drc_pkg::VW-1:0] vs;

	always_comb begin
		vs = side_dv.shifted ? {quo_dv[drc_pkg::VW-2:0], 1'b0} : quo_dv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1 <= 1'b0;
		end else if (en) begin
			vld_c1 <= vld_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_c1 <= (side_dv.force_lim || vs > lim_dec_q) ? lim_dec_q : vs;
			side_c1 <= side_dv;
		end
	end

	// Stage C2: byte length of the value.
	logic        vld_c2;
	logic [drc_pkg::VW-1:0] v_c2;
	logic [5:0]  n_c2;
	drc_pkg::side_t side_c2;
	logic [5:0]  nb;

	always_comb begin
		nb = '0;
		for (int i = 0; i < drc_pkg::VW / 8; i++) begin
			if (v_c1[8*i +: 8] != '0) nb = 6'(i + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c2 <= 1'b0;
		end else if (en) begin
			vld_c2 <= vld_c1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_c2 <= v_c1;
			n_c2 <= nb;
			side_c2 <= side_c1;
		end
	end

	// Stage C3: take the top three bytes and form the compact word, or pass last_bits through.
	logic [31:0] next_c3;
	drc_pkg::side_t side_c3;
	logic [31:0] enc;

	always_comb begin
		logic [drc_pkg::VW+23:0] ext;
		logic [23:0] c;
		logic [5:0]  n;
		ext = {v_c2, 24'h0} >> {n_c2, 3'b000};
		c = ext[23:0];
		n = n_c2;
		if (c[23]) begin
			c = c >> 8;
			n = n + 6'd1;
		end
		enc = side_c2.pass ? side_c2.bits : {2'b00, n, c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_c2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			next_c3 <= enc;
			side_c3 <= side_c2;
		end
	end

	assign m_tdata = next_c3;

	a_encoded_no_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !side_c3.pass |-> !m_tdata[23])
		else $error("encoded result has its sign bit set");

	a_capped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_c1 |-> v_c1 <= lim_dec_q)
		else $error("capped value exceeds the limit");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_c1) && $stable(v_c1) && $stable(vld_s4))
		else $error("pipeline moved during a stall");

endmodule

[rtl/core/drc_div.sv]
// Pipelined 256-bit by 31-bit restoring divider, four quotient bits per stage.
module drc_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [drc_pkg::VW-1:0]  in_x,
	input  logic [30:0]             in_t,
	input  drc_pkg::side_t          in_side,
	output logic                    out_valid,
	output logic [drc_pkg::VW-1:0]  out_x,
	output drc_pkg::side_t          out_side
);

	localparam int unsigned NS = drc_pkg::DIV_STAGES;

	logic                   v_sd    [NS+1];
	logic [drc_pkg::VW-1:0] x_sd    [NS+1];
	logic [30:0]            rem_sd  [NS+1];
	logic [30:0]            t_sd    [NS+1];
	drc_pkg::side_t         side_sd [NS+1];

	assign v_sd[0] = in_valid;
	assign x_sd[0] = in_x;
	assign rem_sd[0] = '0;
	assign t_sd[0] = in_t;
	assign side_sd[0] = in_side;

	for (genvar g = 0; g < NS; g++) begin : g_stage
		drc_pkg::div_res_t res;

		always_comb begin
			res = drc_pkg::div_bits(rem_sd[g], x_sd[g], t_sd[g]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[g+1] <= 1'b0;
			end else if (en) begin
				v_sd[g+1] <= v_sd[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_sd[g+1] <= res.x;
				rem_sd[g+1] <= res.rem;
				t_sd[g+1] <= t_sd[g];
				side_sd[g+1] <= side_sd[g];
			end
		end
	end

	assign out_valid = v_sd[NS];
	assign out_x = x_sd[NS];
	assign out_side = side_sd[NS];

endmodule

[tb/difficulty_retarget_compact_core_test.sv]
// Testbench for the difficulty retarget core: scoreboard with its own predictor under directed and random traffic.
module difficulty_retarget_compact_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned DRAIN_CYCLES = 90;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// block_height[31:0], last_bits[63:32], last_time[127:64], first_time[191:128]
	logic [191:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// next_bits[31:0]
	logic [31:0]  m_tdata;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = drc_pkg::CFG_NO_RETARGET;
	logic [31:0]  cfg_wdata = '0;

	difficulty_retarget_compact_core u_top (.*);

	always #6 clk = ~clk;

	// Register copies used by the predictor.
	logic        cur_no_retarget = drc_pkg::RST_NO_RETARGET;
	logic [30:0] cur_span_wide = drc_pkg::RST_TIMESPAN_WIDE;
	logic [30:0] cur_span_narrow = drc_pkg::RST_TIMESPAN_NARROW;
	logic [31:0] cur_limit = drc_pkg::RST_LIMIT_COMPACT;

	logic [31:0] pending_bits[$];
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned cycles = 0;

	function automatic logic [255:0] unpack_compact(logic [31:0] bits);
		logic [7:0] e;
		logic [255:0] m;
		e = bits[31:24];
		m = {233'b0, bits[22:0]};
		if (e <= 8'd3)
			return m >> (8 * (3 - e));
		if (e >= 8'd35)
			return '0;
		return m << (8 * (e - 3));
	endfunction

	function automatic int unsigned bit_length(logic [255:0] v);
		for (int i = 255; i >= 0; i--)
			if (v[i])
				return i + 1;
		return 0;
	endfunction

	function automatic logic [31:0] pack_compact(logic [255:0] v);
		int unsigned n;
		logic [31:0] c;
		logic [255:0] t;
		n = (bit_length(v) + 7) / 8;
		if (n <= 3) begin
			c = v[31:0] << (8 * (3 - n));
		end else begin
			t = v >> (8 * (n - 3));
			c = t[31:0];
		end
		c &= 32'h00ff_ffff;
		if (c[23]) begin
			c >>= 8;
			n++;
		end
		return c | (n << 24);
	endfunction

	function automatic logic [31:0] scale_target(logic [31:0] bits, logic [63:0] last_t,
		logic [63:0] first_t, logic [30:0] span_t, logic wide);
		logic [255:0] v, lim;
		logic [63:0] lo, hi, span;
		logic shifted;
		if (cur_no_retarget)
			return bits;
		lim = unpack_compact(cur_limit);
		if (span_t == 0)
			return pack_compact(lim);
		if (wide) begin
			lo = span_t / 4;
			hi = 64'(span_t) * 4;
		end else begin
			lo = span_t - span_t / 4;
			hi = 64'(span_t) + span_t / 2;
		end
		if ($signed(last_t) < $signed(first_t))
			span = lo;
		else
			span = last_t - first_t;
		if (span < lo)
			span = lo;
		if (span > hi)
			span = hi;
		v = unpack_compact(bits);
		shifted = bit_length(v) > 235;
		if (shifted)
			v >>= 1;
		v = v * {192'b0, span};
		v = v / {225'b0, span_t};
		if (shifted)
			v <<= 1;
		if (v > lim)
			v = lim;
		return pack_compact(v);
	endfunction

	function automatic logic [31:0] predict_next_bits(logic [31:0] height, logic [31:0] bits,
		logic [63:0] last_t, logic [63:0] first_t);
		logic [32:0] nh;
		nh = {1'b0, height} + 33'd1;
		if (nh < drc_pkg::H_WIDE_END)
			return scale_target(bits, last_t, first_t, cur_span_wide, 1'b1);
		if (nh < drc_pkg::H_NARROW_END)
			return scale_target(bits, last_t, first_t, cur_span_narrow, 1'b0);
		if (nh < drc_pkg::H_LIMIT_END)
			return pack_compact(unpack_compact(cur_limit));
		return scale_target(bits, last_t, first_t, cur_span_narrow, 1'b0);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** difficulty_retarget_compact_core: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_bits.size() == 0) begin
				$error("next_bits: no result expected, got %h", m_tdata);
				errors++;
			end else begin
				want = pending_bits.pop_front();
				if (m_tdata !== want) begin
					$error("next_bits: expected %h, got %h", want, m_tdata);
					errors++;
				end
			end
		end
	end

	task automatic send_header(logic [31:0] height, logic [31:0] bits, logic [63:0] last_t,
		logic [63:0] first_t);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {first_t, last_t, bits, height};
		pending_bits.push_back(predict_next_bits(height, bits, last_t, first_t));
		items_sent++;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_bits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers back to back; the pipeline must be empty.
	task automatic load_registers(logic nr, logic [31:0] tw, logic [31:0] tn, logic [31:0] lim);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= drc_pkg::CFG_NO_RETARGET;
		cfg_wdata <= {31'b0, nr};
		@(posedge clk);
		cfg_index <= drc_pkg::CFG_TIMESPAN_WIDE;
		cfg_wdata <= tw;
		@(posedge clk);
		cfg_index <= drc_pkg::CFG_TIMESPAN_NARROW;
		cfg_wdata <= tn;
		@(posedge clk);
		cfg_index <= drc_pkg::CFG_LIMIT_COMPACT;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_no_retarget = nr;
		cur_span_wide = tw[30:0];
		cur_span_narrow = tn[30:0];
		cur_limit = lim;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_random_header();
		logic [31:0] height, bits, tw;
		logic [63:0] first_t, last_t;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30)
			height = $urandom_range(75998);
		else if (r < 55)
			height = $urandom_range(329527, 75999);
		else if (r < 65)
			height = $urandom_range(329998, 329528);
		else if (r < 85)
			height = $urandom_range(32'hffff_fffe, 329999);
		else if (r < 93)
			height = 32'hffff_fffe - $urandom_range(3);
		else
			height = $urandom_range(75997, 76002);
		r = $urandom_range(99);
		bits = $urandom;
		if (r < 20)
			bits[31:24] = $urandom_range(3);
		else if (r < 80)
			bits[31:24] = $urandom_range(34, 4);
		tw = (height < 75999) ? cur_span_wide : cur_span_narrow;
		first_t = rand64();
		r = $urandom_range(99);
		if (r < 70)
			last_t = first_t + $urandom_range(5 * 4) * (64'(tw) / 4) + $urandom_range(1000);
		else if (r < 85)
			last_t = first_t - $urandom_range(100000);
		else
			last_t = rand64();
		send_header(height, bits, last_t, first_t);
	endtask

	task automatic run_random(int unsigned n);
		for (int i = 0; i < n; i++) begin
			case (i * 4 / n)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 82; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 82; end
				default: begin idle_pct = 16; stall_pct = 16; end
			endcase
			send_random_header();
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	// Mode boundaries, field extremes and the timespan edge cases at reset values.
	task automatic test_directed();
		logic [63:0] tmax, tmin;
		tmax = 64'h7fff_ffff_ffff_ffff;
		tmin = 64'h8000_0000_0000_0000;
		send_header(32'd0, 32'h1d00_ffff, 64'd1000000, 64'd697600);
		send_header(32'd75998, 32'h1d00_ffff, 64'd100, 64'd0);
		send_header(32'd75999, 32'h1c12_3456, 64'd900000, 64'd0);
		send_header(32'd329527, 32'h1b7f_ffff, 64'd302400, 64'd0);
		send_header(32'd329528, 32'h1b00_1234, 64'd1, 64'd0);
		send_header(32'd329998, 32'hffff_ffff, 64'd1, 64'd0);
		send_header(32'd329999, 32'h1d00_ffff, 64'd302400, 64'd0);
		send_header(32'hffff_fffe, 32'h1a05_0000, 64'd302400, 64'd0);
		send_header(32'd10, 32'h0000_0000, tmax, tmin);
		send_header(32'd10, 32'hffff_ffff, tmin, tmax);
		send_header(32'd400000, 32'h2000_ffff, tmax, tmin);
		send_header(32'd400000, 32'h1f7f_ffff, tmin, tmax);
		send_header(32'd5, 32'h0312_3456, 64'd302400, 64'd0);
		send_header(32'd5, 32'h0112_3456, 64'd302400, 64'd0);
		send_header(32'd5, 32'h0280_ffff, 64'd302400, 64'd0);
		send_header(32'd5, 32'h2212_3456, 64'd302400, 64'd0);
		send_header(32'd5, 32'h2300_0001, 64'd302400, 64'd0);
		send_header(32'd5, 32'h0400_0080, 64'd0, 64'd0);
		send_header(32'd80000, 32'h1e00_8000, 64'hffff_ffff_ffff_fff0, 64'hffff_ffff_fffb_0000);
		send_header(32'd80000, 32'h1d80_0000, 64'd302400, 64'd302400);
	endtask

	task automatic test_default_registers();
		run_random(500);
	endtask

	task automatic test_register_extremes();
		load_registers(1'b0, 32'd1, 32'h7fff_ffff, 32'hffff_ffff);
		run_random(300);
		load_registers(1'b0, 32'h7fff_ffff, 32'd1, 32'h0000_0000);
		run_random(250);
		load_registers(1'b0, 32'hffff_ffff, 32'h8000_0003, 32'h2100_ffff);
		run_random(150);
	endtask

	task automatic test_no_retarget();
		load_registers(1'b1, 32'd600, 32'd300, 32'h207f_ffff);
		run_random(150);
	endtask

	task automatic test_zero_timespan();
		load_registers(1'b0, 32'd0, 32'd0, 32'h1d00_ffff);
		run_random(100);
	endtask

	task automatic test_random_registers();
		for (int k = 0; k < 3; k++) begin
			load_registers($urandom_range(3) == 0, $urandom_range(5000000, 1), $urandom,
				$urandom);
			run_random(100);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_default_registers();
		test_register_extremes();
		test_no_retarget();
		test_zero_timespan();
		test_random_registers();
		wait_idle();
		$display("Sent %0d headers across all modes and register settings; checked %0d results.",
			items_sent, results_seen);
		if (errors == 0 && pending_bits.size() == 0)
			$display("** difficulty_retarget_compact_core: PASSED **");
		else
			$display("** difficulty_retarget_compact_core: FAILED **");
		$finish;
	end

endmodule
